>>> hw/rtl/v3a_pkg.sv
// Shared types, constants and helper functions for the vector unit.
`timescale 1ns / 1ps

package v3a_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int QUO_BITS   = FRAC_BITS + 1;
   localparam int ROOT_BITS  = 32;
   localparam int SQRT_STEPS = ROOT_BITS;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_SUB   = 3'd1;
   localparam logic [2:0] OP_CROSS = 3'd2;
   localparam logic [2:0] OP_DOT   = 3'd3;
   localparam logic [2:0] OP_SCALE = 3'd4;
   localparam logic [2:0] OP_LEN   = 3'd5;
   localparam logic [2:0] OP_NORM  = 3'd6;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic signed [31:0] bz;
      logic signed [31:0] scale_factor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic signed [31:0] rz;
      logic signed [31:0] scalar;
      logic               zero_length;
      logic               saturated;
   } rsp_type;

   // What travels beside the square root and divider stages.
   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] az;
      rsp_type            early;
   } side_type;

   function automatic logic signed [31:0] sat_val(input logic signed [65:0] x);
      logic signed [31:0] res;
      if (x > 66'sd2147483647) begin
         res = 32'sh7fffffff;
      end else if (x < -66'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

   function automatic logic sat_ovf(input logic signed [65:0] x);
      return (x > 66'sd2147483647) || (x < -66'sd2147483648);
   endfunction

endpackage

>>> hw/rtl/v3a_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module v3a_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2*v3a_pkg::ROOT_BITS-1:0]  in_square,
   input  v3a_pkg::side_type                in_side,
   output logic                             out_valid,
   output logic [v3a_pkg::ROOT_BITS-1:0]    out_root,
   output v3a_pkg::side_type                out_side
);
   import v3a_pkg::*;

   localparam int RW = ROOT_BITS;
   localparam int NW = 2 * ROOT_BITS;

   logic           valid_ff [SQRT_STEPS];
   logic [RW+1:0]  rem_ff   [SQRT_STEPS];
   logic [RW-1:0]  root_ff  [SQRT_STEPS];
   logic [NW-1:0]  num_ff   [SQRT_STEPS];
   side_type       side_ff  [SQRT_STEPS];

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      logic          cur_valid;
      logic [RW+1:0] cur_rem;
      logic [RW-1:0] cur_root;
      logic [NW-1:0] cur_num;
      side_type      cur_side;
      logic [RW+3:0] rem_pre;
      logic [RW+3:0] trial;
      logic [RW+3:0] diff;
      logic          ge;

      if (g == 0) begin : g_first
         assign cur_valid = in_valid;
         assign cur_rem   = '0;
         assign cur_root  = '0;
         assign cur_num   = in_square;
         assign cur_side  = in_side;
      end else begin : g_next
         assign cur_valid = valid_ff[g-1];
         assign cur_rem   = rem_ff[g-1];
         assign cur_root  = root_ff[g-1];
         assign cur_num   = num_ff[g-1];
         assign cur_side  = side_ff[g-1];
      end

      // Bring down the next two bits and try the digit one.
      assign rem_pre = {cur_rem, cur_num[NW-1:NW-2]};
      assign trial   = {2'b00, cur_root, 2'b01};
      assign diff    = rem_pre - trial;
      assign ge      = rem_pre >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= cur_valid;
         end
         rem_ff[g]  <= ge ? diff[RW+1:0] : rem_pre[RW+1:0];
         root_ff[g] <= {cur_root[RW-2:0], ge};
         num_ff[g]  <= {cur_num[NW-3:0], 2'b00};
         side_ff[g] <= cur_side;
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

>>> hw/rtl/v3a_div.sv
// Pipelined three-lane divider for normalize, one quotient bit per stage.
`timescale 1ns / 1ps

module v3a_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [31:0]                           in_len,
   input  v3a_pkg::side_type                     in_side,
   output logic                                  out_valid,
   output logic [31:0]                           out_len,
   output logic [2:0][v3a_pkg::QUO_BITS-1:0]     out_quo,
   output v3a_pkg::side_type                     out_side
);
   import v3a_pkg::*;

   localparam int QW = QUO_BITS;

   logic          valid_ff [QW];
   logic [31:0]   len_ff   [QW];
   logic [31:0]   rem_ff   [QW][3];
   logic [QW-1:0] quo_ff   [QW][3];
   side_type      side_ff  [QW];

   for (genvar g = 0; g < QW; g++) begin : g_step
      logic          cur_valid;
      logic [31:0]   cur_len;
      logic [31:0]   cur_rem [3];
      logic [QW-1:0] cur_quo [3];
      logic          cur_bit [3];
      side_type      cur_side;
      logic [32:0]   rem_pre [3];
      logic [32:0]   diff    [3];
      logic          ge      [3];

      if (g == 0) begin : g_first
         logic [31:0] mag [3];
         // The dividend is mag shifted up by the fraction width; since the
         // quotient stays within QW bits, the division starts at its top.
         always_comb begin
            mag[0] = in_side.ax[31] ? 32'(-in_side.ax) : in_side.ax;
            mag[1] = in_side.ay[31] ? 32'(-in_side.ay) : in_side.ay;
            mag[2] = in_side.az[31] ? 32'(-in_side.az) : in_side.az;
            for (int l = 0; l < 3; l++) begin
               cur_rem[l] = {1'b0, mag[l][31:1]};
               cur_bit[l] = mag[l][0];
               cur_quo[l] = '0;
            end
         end
         assign cur_valid = in_valid;
         assign cur_len   = in_len;
         assign cur_side  = in_side;
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < 3; l++) begin
               cur_rem[l] = rem_ff[g-1][l];
               cur_bit[l] = 1'b0;
               cur_quo[l] = quo_ff[g-1][l];
            end
         end
         assign cur_valid = valid_ff[g-1];
         assign cur_len   = len_ff[g-1];
         assign cur_side  = side_ff[g-1];
      end

      always_comb begin
         for (int l = 0; l < 3; l++) begin
            rem_pre[l] = {cur_rem[l], cur_bit[l]};
            diff[l]    = rem_pre[l] - {1'b0, cur_len};
            ge[l]      = rem_pre[l] >= {1'b0, cur_len};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= cur_valid;
         end
         len_ff[g]  <= cur_len;
         side_ff[g] <= cur_side;
         for (int l = 0; l < 3; l++) begin
            rem_ff[g][l] <= ge[l] ? diff[l][31:0] : rem_pre[l][31:0];
            quo_ff[g][l] <= {cur_quo[l][QW-2:0], ge[l]};
         end
      end
   end

   assign out_valid  = valid_ff[QW-1];
   assign out_len    = len_ff[QW-1];
   assign out_side   = side_ff[QW-1];
   assign out_quo[0] = quo_ff[QW-1][0];
   assign out_quo[1] = quo_ff[QW-1][1];
   assign out_quo[2] = quo_ff[QW-1][2];

endmodule

>>> hw/rtl/vector3_alu.sv
// Top level of the three-component fixed-point vector unit.
`timescale 1ns / 1ps

//  Channel   Ports                   Moves            Handshake
//  request   start, busy, req_data   req_type word    taken when start and not busy
//  result    rsp_strobe, rsp_data    rsp_type word    one-cycle strobe, no back-pressure
//
// Every opcode runs the same fixed-latency pipeline: six front stages (request
// capture, multiply, difference, two adds, truncation and clipping), SQRT_STEPS
// square root stages and QUO_BITS divider stages, then the output register:
// 39 + FRAC_BITS + 1 stages, 56 at Q16.16. A word is taken in every cycle in which busy is low.
// Reset clears the valid bits; busy is a registered copy of reset, high in each cycle after one with reset high.
// The receiver cannot stall, so nothing in the pipeline ever waits.

module vector3_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  v3a_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output v3a_pkg::rsp_type  rsp_data
);
   import v3a_pkg::*;

   logic busy_ff;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   req_type            r1_ff, r2_ff, r3_ff, r4_ff, r5_ff;
   logic signed [31:0] opa [6];
   logic signed [31:0] opb [6];
   logic signed [63:0] prod_in [6];
   logic signed [63:0] prod_ff [6];
   logic signed [31:0] a2 [3];
   logic signed [31:0] b2 [3];
   logic signed [64:0] d3_in [3];
   logic signed [64:0] d3_ff [3];
   logic signed [64:0] d4_ff [3];
   logic signed [64:0] d5_ff [3];
   logic signed [65:0] sum4_ff;
   logic signed [65:0] total5_ff;
   logic signed [64:0] shifted [3];
   logic signed [65:0] dot_sh;
   side_type           side6_in, side6_ff;
   logic [63:0]        square6_in, square6_ff;

   logic                        sq_valid;
   logic [ROOT_BITS-1:0]        sq_root;
   side_type                    sq_side;
   logic                        dv_valid;
   logic [31:0]                 dv_len;
   logic [2:0][QUO_BITS-1:0]    dv_quo;
   side_type                    dv_side;

   rsp_type rsp_in, rsp_ff;
   logic    strobe_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end
   assign busy = busy_ff;

   // Stage 1: capture the request word.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy_ff;
      end
      r1_ff <= req_data;
   end

   // Stage 2: six shared multipliers; pairs 0/1, 2/3, 4/5 feed one lane each.
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         opa[k] = '0;
         opb[k] = '0;
      end
      unique case (r1_ff.opcode)
         OP_CROSS: begin
            opa[0] = r1_ff.ay; opb[0] = r1_ff.bz;
            opa[1] = r1_ff.az; opb[1] = r1_ff.by;
            opa[2] = r1_ff.az; opb[2] = r1_ff.bx;
            opa[3] = r1_ff.ax; opb[3] = r1_ff.bz;
            opa[4] = r1_ff.ax; opb[4] = r1_ff.by;
            opa[5] = r1_ff.ay; opb[5] = r1_ff.bx;
         end
         OP_DOT: begin
            opa[0] = r1_ff.ax; opb[0] = r1_ff.bx;
            opa[2] = r1_ff.ay; opb[2] = r1_ff.by;
            opa[4] = r1_ff.az; opb[4] = r1_ff.bz;
         end
         OP_SCALE: begin
            opa[0] = r1_ff.ax; opb[0] = r1_ff.scale_factor;
            opa[2] = r1_ff.ay; opb[2] = r1_ff.scale_factor;
            opa[4] = r1_ff.az; opb[4] = r1_ff.scale_factor;
         end
         OP_LEN, OP_NORM: begin
            opa[0] = r1_ff.ax; opb[0] = r1_ff.ax;
            opa[2] = r1_ff.ay; opb[2] = r1_ff.ay;
            opa[4] = r1_ff.az; opb[4] = r1_ff.az;
         end
         default: begin
         end
      endcase
      for (int k = 0; k < 6; k++) begin
         prod_in[k] = opa[k] * opb[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      r2_ff <= r1_ff;
      for (int k = 0; k < 6; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   // Stage 3: per-lane sum, difference or product difference.
   assign a2[0] = r2_ff.ax;
   assign a2[1] = r2_ff.ay;
   assign a2[2] = r2_ff.az;
   assign b2[0] = r2_ff.bx;
   assign b2[1] = r2_ff.by;
   assign b2[2] = r2_ff.bz;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (r2_ff.opcode == OP_ADD) begin
            d3_in[i] = 65'(a2[i]) + 65'(b2[i]);
         end else if (r2_ff.opcode == OP_SUB) begin
            d3_in[i] = 65'(a2[i]) - 65'(b2[i]);
         end else begin
            d3_in[i] = 65'(prod_ff[2*i]) - 65'(prod_ff[2*i+1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      r3_ff <= r2_ff;
      for (int i = 0; i < 3; i++) begin
         d3_ff[i] <= d3_in[i];
      end
   end

   // Stages 4 and 5: three-term sum for dot, length and normalize.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      r4_ff     <= r3_ff;
      r5_ff     <= r4_ff;
      sum4_ff   <= 66'(d3_ff[0]) + 66'(d3_ff[1]);
      total5_ff <= sum4_ff + 66'(d4_ff[2]);
      for (int i = 0; i < 3; i++) begin
         d4_ff[i] <= d3_ff[i];
         d5_ff[i] <= d4_ff[i];
      end
   end

   // Stage 6: truncation by arithmetic shift and clipping.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         shifted[i] = d5_ff[i] >>> FRAC_BITS;
      end
      dot_sh = total5_ff >>> FRAC_BITS;

      side6_in.opcode = r5_ff.opcode;
      side6_in.ax     = r5_ff.ax;
      side6_in.ay     = r5_ff.ay;
      side6_in.az     = r5_ff.az;
      side6_in.early  = '0;
      square6_in      = total5_ff[63:0];

      unique case (r5_ff.opcode)
         OP_ADD, OP_SUB: begin
            side6_in.early.rx        = sat_val(66'(d5_ff[0]));
            side6_in.early.ry        = sat_val(66'(d5_ff[1]));
            side6_in.early.rz        = sat_val(66'(d5_ff[2]));
            side6_in.early.saturated = sat_ovf(66'(d5_ff[0])) || sat_ovf(66'(d5_ff[1]))
                                       || sat_ovf(66'(d5_ff[2]));
         end
         OP_CROSS, OP_SCALE: begin
            side6_in.early.rx        = sat_val(66'(shifted[0]));
            side6_in.early.ry        = sat_val(66'(shifted[1]));
            side6_in.early.rz        = sat_val(66'(shifted[2]));
            side6_in.early.saturated = sat_ovf(66'(shifted[0])) || sat_ovf(66'(shifted[1]))
                                       || sat_ovf(66'(shifted[2]));
         end
         OP_DOT: begin
            side6_in.early.scalar    = sat_val(dot_sh);
            side6_in.early.saturated = sat_ovf(dot_sh);
         end
         OP_LEN, OP_NORM: begin
            side6_in.early.zero_length = (total5_ff == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      side6_ff   <= side6_in;
      square6_ff <= square6_in;
   end

   v3a_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_square (square6_ff),
      .in_side   (side6_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   v3a_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_len    (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_len   (dv_len),
      .out_quo   (dv_quo),
      .out_side  (dv_side)
   );

   // Output stage: length and normalize take their values from the root and
   // quotients; every other opcode already carries its word.
   always_comb begin
      logic signed [31:0] q [3];
      logic               neg [3];
      rsp_in = dv_side.early;
      neg[0] = dv_side.ax[31];
      neg[1] = dv_side.ay[31];
      neg[2] = dv_side.az[31];
      for (int l = 0; l < 3; l++) begin
         q[l] = neg[l] ? -32'(dv_quo[l]) : 32'(dv_quo[l]);
      end
      if ((dv_side.opcode == OP_LEN || dv_side.opcode == OP_NORM)
          && !dv_side.early.zero_length) begin
         rsp_in.scalar    = dv_len[31] ? 32'sh7fffffff : dv_len;
         rsp_in.saturated = dv_len[31];
         if (dv_side.opcode == OP_NORM) begin
            rsp_in.rx = q[0];
            rsp_in.ry = q[1];
            rsp_in.rz = q[2];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_busy_only_after_reset: assert property (@(posedge clock)
      !reset |=> !busy)
      else $error("busy high without a preceding reset");

   a_zero_length_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.zero_length |->
         rsp_data.scalar == '0 && rsp_data.rx == '0 && rsp_data.ry == '0
         && rsp_data.rz == '0 && !rsp_data.saturated)
      else $error("zero-length word carries nonzero values");

   a_unit_quotient: assert property (@(posedge clock) disable iff (reset)
      dv_valid && dv_side.opcode == OP_NORM && !dv_side.early.zero_length |->
         dv_quo[0] <= QUO_BITS'(1 << FRAC_BITS) && dv_quo[1] <= QUO_BITS'(1 << FRAC_BITS)
         && dv_quo[2] <= QUO_BITS'(1 << FRAC_BITS))
      else $error("normalize quotient above one");

endmodule
